// ===== sv/isotp_pkg.sv =====
// Shared types, codes and result builders for the ISO-TP response reassembler.
// No dependencies; imported by every module of the block.
package isotp_pkg;

    // wait counter width and input wait field width
    localparam int WAIT_CNT_W = 16;
    localparam int WAIT_IN_W  = 16;

    // operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_CHUNK  = 2'd0;
    localparam logic [1:0] KIND_FC     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // final status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NEG     = 2'd1;
    localparam logic [1:0] ST_ERR     = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // flow-control status codes
    localparam logic [1:0] FS_CTS      = 2'd0;
    localparam logic [1:0] FS_OVERFLOW = 2'd2;

    // receiver phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_AWAIT = 2'd1;
    localparam logic [1:0] PH_RECV  = 2'd2;

    // frame type nibbles
    localparam logic [3:0] PCI_SINGLE = 4'd0;
    localparam logic [3:0] PCI_FIRST  = 4'd1;
    localparam logic [3:0] PCI_CONSEC = 4'd2;

    // configuration register indexes
    localparam logic CFG_MAX_LENGTH  = 1'b0;
    localparam logic CFG_GAP_TIMEOUT = 1'b1;

    // identifiers and magic values
    localparam logic [28:0] RESP_EXT_ID   = 29'h18DAF100;
    localparam logic [28:0] RESP_EXT_MASK = 29'h1FFFFF00;
    localparam logic [28:0] RESP_STD_ID   = 29'h7E8;
    localparam logic [28:0] FC_ID_BASE    = 29'h18DA0000;
    localparam logic [7:0]  FC_ID_LOW     = 8'hF1;
    localparam logic [7:0]  NEG_SID       = 8'h7F;
    localparam logic [7:0]  MAX_LEN_RST   = 8'd255;
    localparam logic [7:0]  GAP_TMO_RST   = 8'd50;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] wait_ms;
        logic [28:0] frame_id;
        logic        is_extended;
        logic [63:0] frame_bytes;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [55:0] chunk_bytes;
        logic [2:0]  chunk_count;
        logic [7:0]  byte_offset;
        logic [28:0] fc_id;
        logic [1:0]  flow_status;
        logic [1:0]  status;
        logic [7:0]  message_length;
        logic [7:0]  nrc;
        logic        last;
    } result_t;

    // up to two results for one request
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
    } core_out_t;

    // keep the first count bytes of a chunk, clear the rest
    function automatic logic [55:0] chunk_mask(input logic [2:0] count);
        logic [55:0] m;
        m = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < count) begin
                m[55 - 8 * i -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic result_t mk_chunk(input logic [55:0] bytes, input logic [2:0] count,
                                         input logic [7:0] offset);
        result_t r;
        r = '0;
        r.kind        = KIND_CHUNK;
        r.chunk_bytes = bytes & chunk_mask(count);
        r.chunk_count = count;
        r.byte_offset = offset;
        return r;
    endfunction

    function automatic result_t mk_fc(input logic [28:0] id, input logic [1:0] fs);
        result_t r;
        r = '0;
        r.kind        = KIND_FC;
        r.fc_id       = FC_ID_BASE | {13'd0, id[7:0], FC_ID_LOW};
        r.flow_status = fs;
        return r;
    endfunction

    function automatic result_t mk_status(input logic [1:0] st, input logic [7:0] len,
                                          input logic [7:0] code);
        result_t r;
        r = '0;
        r.kind           = KIND_STATUS;
        r.status         = st;
        r.message_length = len;
        r.nrc            = code;
        return r;
    endfunction

    // clamp the requested wait to the counter range
    function automatic logic [WAIT_CNT_W-1:0] sat_wait(input logic [WAIT_IN_W-1:0] w);
        logic [31:0] w32;
        w32 = 32'(w);
        if (|(w32 >> WAIT_CNT_W)) begin
            return '1;
        end
        return w32[WAIT_CNT_W-1:0];
    endfunction

endpackage

// ===== sv/isotp_response_reassembler.sv =====
// ISO-TP response reassembler: one request of start, received frame or
// millisecond tick enters per cycle through an input register while the output
// has room; the core decides on it against the receiver state and loads up to two
// results (payload chunk, flow-control frame, final status) into a two-slot output
// register. A request that gives two results holds off the next request until the
// first of them has left; results leave one per cycle while m_tready is high.
// Configuration is a plain write port: index 0 max_length, index 1
// gap_timeout_ms. Depends on isotp_pkg, isotp_in_stage, isotp_core and
// isotp_out_stage.
module isotp_response_reassembler
    import isotp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_wdata,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // wait_ms[15:0], frame_id[44:16], is_extended[45], frame_bytes[109:46], zero pad
    input  logic [111:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // chunk_bytes[55:0], chunk_count[58:56], byte_offset[66:59], fc_id[95:67],
    // flow_status[97:96], status[99:98], message_length[107:100], nrc[115:108], zero pad
    output logic [119:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    item_t     in_item, item;
    logic      item_valid;
    logic      room, fire;
    core_out_t core_out;
    result_t   out_res;

    // unpack the request
    assign in_item.operation   = s_tuser;
    assign in_item.wait_ms     = s_tdata[15:0];
    assign in_item.frame_id    = s_tdata[44:16];
    assign in_item.is_extended = s_tdata[45];
    assign in_item.frame_bytes = s_tdata[109:46];

    assign fire = item_valid && room;

    isotp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    isotp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .fire      (fire),
        .core_out  (core_out)
    );

    isotp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .core_out  (core_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack the result
    assign m_tdata = {4'd0, out_res.nrc, out_res.message_length, out_res.status,
                      out_res.flow_status, out_res.fc_id, out_res.byte_offset,
                      out_res.chunk_count, out_res.chunk_bytes};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== sv/isotp_in_stage.sv =====
// Input register for request items of the reassembler.
// Depends on isotp_pkg for the item type.
module isotp_in_stage
    import isotp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  accept;

    // a held request leaves when the core takes it
    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/isotp_core.sv =====
// Receiver state, configuration registers and per-request decision logic.
// Depends on isotp_pkg for item, result types, codes and result builders.
module isotp_core
    import isotp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  item_t      item,
    input  logic       fire,
    output core_out_t  core_out
);

    logic [7:0]            max_length_reg;
    logic [7:0]            gap_timeout_reg;
    logic [1:0]            phase_reg, phase_next;
    logic [WAIT_CNT_W-1:0] wait_reg, wait_next;
    logic [7:0]            gap_reg, gap_next;
    logic [3:0]            seq_reg, seq_next;
    logic [7:0]            br_reg, br_next;
    logic [7:0]            tl_reg, tl_next;
    logic [28:0]           sender_reg, sender_next;

    logic [7:0]            b0, byte1, byte3;
    logic [3:0]            pci, low;
    logic                  match;
    logic [11:0]           first_len;
    logic [7:0]            remain;
    logic [2:0]            cf_count;
    logic [WAIT_CNT_W-1:0] wait_dec;
    result_t               res0, res1;
    logic [1:0]            count;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg  <= MAX_LEN_RST;
            gap_timeout_reg <= GAP_TMO_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_LENGTH:  max_length_reg  <= cfg_wdata;
                CFG_GAP_TIMEOUT: gap_timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame header fields and response filter
    assign b0        = item.frame_bytes[63:56];
    assign byte1     = item.frame_bytes[55:48];
    assign byte3     = item.frame_bytes[39:32];
    assign pci       = b0[7:4];
    assign low       = b0[3:0];
    assign match     = item.is_extended ? ((item.frame_id & RESP_EXT_MASK) == RESP_EXT_ID)
                                        : (item.frame_id == RESP_STD_ID);
    assign first_len = {low, byte1};
    assign remain    = (tl_reg > br_reg) ? (tl_reg - br_reg) : 8'd0;
    assign cf_count  = (remain < 8'd7) ? remain[2:0] : 3'd7;
    assign wait_dec  = (wait_reg != '0) ? (wait_reg - WAIT_CNT_W'(1)) : wait_reg;

    // per-request decisions
    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        gap_next    = gap_reg;
        seq_next    = seq_reg;
        br_next     = br_reg;
        tl_next     = tl_reg;
        sender_next = sender_reg;
        res0        = '0;
        res1        = '0;
        count       = 2'd0;
        unique case (item.operation)
            OP_START: begin
                phase_next = PH_IDLE;
                wait_next  = '0;
                gap_next   = 8'd0;
                if (item.wait_ms == '0) begin
                    res0  = mk_status(ST_TIMEOUT, 8'd0, 8'd0);
                    count = 2'd1;
                end else begin
                    phase_next = PH_AWAIT;
                    wait_next  = sat_wait(item.wait_ms);
                end
            end
            OP_TICK: begin
                if (phase_reg == PH_AWAIT) begin
                    wait_next = wait_dec;
                    if (wait_dec == '0) begin
                        phase_next = PH_IDLE;
                        gap_next   = 8'd0;
                        res0       = mk_status(ST_TIMEOUT, 8'd0, 8'd0);
                        count      = 2'd1;
                    end
                end else if (phase_reg == PH_RECV) begin
                    if (gap_reg >= gap_timeout_reg) begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        gap_next   = 8'd0;
                        res0       = mk_status(ST_ERR, 8'd0, 8'd0);
                        count      = 2'd1;
                    end else begin
                        gap_next = gap_reg + 8'd1;
                    end
                end
            end
            OP_FRAME: begin
                if (match && phase_reg == PH_AWAIT) begin
                    if (pci == PCI_SINGLE) begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        gap_next   = 8'd0;
                        if (low == 4'd0 || low > 4'd7 || {4'd0, low} > max_length_reg) begin
                            res0  = mk_status(ST_ERR, 8'd0, 8'd0);
                            count = 2'd1;
                        end else begin
                            res0 = mk_chunk(item.frame_bytes[55:0], low[2:0], 8'd0);
                            // service byte 7F marks a negative response
                            if (low >= 4'd3 && byte1 == NEG_SID) begin
                                res1 = mk_status(ST_NEG, {4'd0, low}, byte3);
                            end else begin
                                res1 = mk_status(ST_OK, {4'd0, low}, 8'd0);
                            end
                            count = 2'd2;
                        end
                    end else if (pci == PCI_FIRST && item.is_extended) begin
                        if (first_len < 12'd8) begin
                            phase_next = PH_IDLE;
                            wait_next  = '0;
                            gap_next   = 8'd0;
                            res0       = mk_status(ST_ERR, 8'd0, 8'd0);
                            count      = 2'd1;
                        end else if (first_len > {4'd0, max_length_reg}) begin
                            phase_next = PH_IDLE;
                            wait_next  = '0;
                            gap_next   = 8'd0;
                            res0       = mk_fc(item.frame_id, FS_OVERFLOW);
                            res1       = mk_status(ST_ERR, 8'd0, 8'd0);
                            count      = 2'd2;
                        end else begin
                            res0        = mk_chunk({item.frame_bytes[47:0], 8'd0}, 3'd6, 8'd0);
                            res1        = mk_fc(item.frame_id, FS_CTS);
                            count       = 2'd2;
                            phase_next  = PH_RECV;
                            wait_next   = '0;
                            gap_next    = 8'd0;
                            seq_next    = 4'd1;
                            br_next     = 8'd6;
                            tl_next     = first_len[7:0];
                            sender_next = item.frame_id;
                        end
                    end
                end else if (match && phase_reg == PH_RECV && pci == PCI_CONSEC
                             && item.frame_id == sender_reg) begin
                    if (low != seq_reg) begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        gap_next   = 8'd0;
                        res0       = mk_status(ST_ERR, 8'd0, 8'd0);
                        count      = 2'd1;
                    end else begin
                        res0     = mk_chunk(item.frame_bytes[55:0], cf_count, br_reg);
                        count    = 2'd1;
                        br_next  = br_reg + {5'd0, cf_count};
                        seq_next = seq_reg + 4'd1;
                        gap_next = 8'd0;
                        // whole message in
                        if (br_next >= tl_reg) begin
                            phase_next = PH_IDLE;
                            wait_next  = '0;
                            res1       = mk_status(ST_OK, tl_reg, 8'd0);
                            count      = 2'd2;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (count == 2'd1) begin
            res0.last = 1'b1;
        end else if (count == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign core_out.res0  = res0;
    assign core_out.res1  = res1;
    assign core_out.count = count;

    // receiver state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            wait_reg   <= '0;
            gap_reg    <= 8'd0;
            seq_reg    <= 4'd1;
            br_reg     <= 8'd0;
            tl_reg     <= 8'd0;
            sender_reg <= 29'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            gap_reg    <= gap_next;
            seq_reg    <= seq_next;
            br_reg     <= br_next;
            tl_reg     <= tl_next;
            sender_reg <= sender_next;
        end
    end

    // outside the await phase the wait counter is clear
    a_wait_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_AWAIT) |-> (wait_reg == '0))
        else $error("wait counter live outside await phase");

    // awaiting a response always has budget left
    a_wait_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_AWAIT) |-> (wait_reg != '0))
        else $error("await phase with empty wait budget");

    // a message in progress is never already complete
    a_recv_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RECV) |-> (br_reg < tl_reg))
        else $error("receiving with all bytes already in");

    // idle leaves the gap counter cleared
    a_gap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (gap_reg == 8'd0))
        else $error("gap counter running while idle");

endmodule

// ===== sv/isotp_out_stage.sv =====
// Two-slot result register that delivers core results one per cycle while out_ready is high.
// Depends on isotp_pkg for the result types.
module isotp_out_stage
    import isotp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  core_out_t core_out,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    result_t    slot0_reg, slot1_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    // new results may load once the slots drain this cycle
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign out_res   = slot0_reg;

    always_comb begin
        count_next = count_reg;
        if (fire) begin
            count_next = core_out.count;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result slots, head in slot 0
    always_ff @(posedge aclk) begin
        if (fire) begin
            slot0_reg <= core_out.res0;
            slot1_reg <= core_out.res1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== verif/isotp_reassembly_checker.sv =====
// Scoreboard for the ISO-TP response reassembler: follows configuration writes and
// accepted requests, predicts the results, and compares the result channel against them.
// Depends on isotp_pkg for the request and result layouts and the code names.
module isotp_reassembly_checker
    import isotp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // wait_ms[15:0], frame_id[44:16], is_extended[45], frame_bytes[109:46], zero pad
    input  logic [111:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // chunk_bytes[55:0], chunk_count[58:56], byte_offset[66:59], fc_id[95:67],
    // flow_status[97:96], status[99:98], message_length[107:100], nrc[115:108], zero pad
    input  logic [119:0] m_tdata,
    // kind[1:0]
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatches,
    output int           outstanding
);

    localparam logic [28:0] EXT_RESP_BASE = 29'h18DAF100;
    localparam logic [28:0] EXT_RESP_MASK = 29'h1FFFFF00;
    localparam logic [28:0] STD_RESP_ID   = 29'h7E8;
    localparam logic [28:0] FLOW_ID_BASE  = 29'h18DA00F1;
    localparam logic [7:0]  NEG_REPLY_SID = 8'h7F;

    // results still owed by the block, oldest first
    result_t expected_results[$];

    // receiver state as the block should hold it
    logic [1:0]  rx_phase;
    logic [15:0] wait_left;
    logic [7:0]  gap_count;
    logic [3:0]  next_seq;
    logic [7:0]  bytes_done;
    logic [7:0]  msg_total;
    logic [28:0] sender;
    logic [7:0]  len_limit;
    logic [7:0]  gap_limit;

    int      fails;
    item_t   req_seen;
    result_t seen;
    result_t want;

    function automatic logic [7:0] frame_byte(input logic [63:0] fb, input int idx);
        return fb[63 - 8 * idx -: 8];
    endfunction

    function automatic result_t chunk_result(input logic [63:0] fb, input int first,
                                             input int count, input logic [7:0] offset);
        result_t r;
        r = '0;
        r.kind = KIND_CHUNK;
        for (int i = 0; i < count; i++) begin
            r.chunk_bytes[55 - 8 * i -: 8] = frame_byte(fb, first + i);
        end
        r.chunk_count = 3'(count);
        r.byte_offset = offset;
        return r;
    endfunction

    function automatic result_t flow_result(input logic [28:0] id, input logic [1:0] fs);
        result_t r;
        r = '0;
        r.kind        = KIND_FC;
        r.fc_id       = FLOW_ID_BASE | {13'd0, id[7:0], 8'd0};
        r.flow_status = fs;
        return r;
    endfunction

    function automatic result_t status_result(input logic [1:0] st, input logic [7:0] len,
                                              input logic [7:0] code);
        result_t r;
        r = '0;
        r.kind           = KIND_STATUS;
        r.status         = st;
        r.message_length = len;
        r.nrc            = code;
        return r;
    endfunction

    function automatic string describe(input result_t r);
        string head;
        head = $sformatf("kind %0d bytes %014h count %0d offset %0d ", r.kind, r.chunk_bytes,
                         r.chunk_count, r.byte_offset);
        return {head, $sformatf("fc_id %08h fs %0d status %0d len %0d nrc %02h last %0d",
                                r.fc_id, r.flow_status, r.status, r.message_length, r.nrc,
                                r.last)};
    endfunction

    function automatic void drop_transfer();
        rx_phase  = PH_IDLE;
        wait_left = '0;
        gap_count = '0;
    endfunction

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // work out what one request produces and advance the receiver state
    task automatic reassemble(input item_t req);
        result_t     batch[$];
        logic [7:0]  b0;
        logic [3:0]  pci;
        logic [11:0] first_len;
        logic [7:0]  remain;
        logic [7:0]  take;
        logic        hit;

        b0  = req.frame_bytes[63:56];
        pci = b0[7:4];
        case (req.operation)
            OP_START: begin
                drop_transfer();
                if (req.wait_ms == '0) begin
                    batch.push_back(status_result(ST_TIMEOUT, 8'd0, 8'd0));
                end else begin
                    rx_phase  = PH_AWAIT;
                    wait_left = req.wait_ms;
                end
            end
            OP_TICK: begin
                if (rx_phase == PH_AWAIT) begin
                    if (wait_left != '0) begin
                        wait_left = wait_left - 1'b1;
                    end
                    if (wait_left == '0) begin
                        drop_transfer();
                        batch.push_back(status_result(ST_TIMEOUT, 8'd0, 8'd0));
                    end
                end else if (rx_phase == PH_RECV) begin
                    if (gap_count >= gap_limit) begin
                        drop_transfer();
                        batch.push_back(status_result(ST_ERR, 8'd0, 8'd0));
                    end else begin
                        gap_count = gap_count + 1'b1;
                    end
                end
            end
            OP_FRAME: begin
                hit = req.is_extended ? ((req.frame_id & EXT_RESP_MASK) == EXT_RESP_BASE)
                                      : (req.frame_id == STD_RESP_ID);
                if (hit && rx_phase == PH_AWAIT) begin
                    if (pci == PCI_SINGLE) begin
                        drop_transfer();
                        if (b0[3:0] == 4'd0 || b0[3:0] > 4'd7 || {4'd0, b0[3:0]} > len_limit) begin
                            batch.push_back(status_result(ST_ERR, 8'd0, 8'd0));
                        end else begin
                            batch.push_back(chunk_result(req.frame_bytes, 1, b0[3:0], 8'd0));
                            // service byte 7F marks a negative reply, code in byte 3
                            if (b0[3:0] >= 4'd3 && frame_byte(req.frame_bytes, 1) == NEG_REPLY_SID) begin
                                batch.push_back(status_result(ST_NEG, {4'd0, b0[3:0]},
                                                              frame_byte(req.frame_bytes, 3)));
                            end else begin
                                batch.push_back(status_result(ST_OK, {4'd0, b0[3:0]}, 8'd0));
                            end
                        end
                    end else if (pci == PCI_FIRST && req.is_extended) begin
                        first_len = {b0[3:0], frame_byte(req.frame_bytes, 1)};
                        if (first_len < 12'd8) begin
                            drop_transfer();
                            batch.push_back(status_result(ST_ERR, 8'd0, 8'd0));
                        end else if (first_len > {4'd0, len_limit}) begin
                            drop_transfer();
                            batch.push_back(flow_result(req.frame_id, FS_OVERFLOW));
                            batch.push_back(status_result(ST_ERR, 8'd0, 8'd0));
                        end else begin
                            batch.push_back(chunk_result(req.frame_bytes, 2, 6, 8'd0));
                            batch.push_back(flow_result(req.frame_id, FS_CTS));
                            rx_phase   = PH_RECV;
                            wait_left  = '0;
                            gap_count  = '0;
                            next_seq   = 4'd1;
                            bytes_done = 8'd6;
                            msg_total  = first_len[7:0];
                            sender     = req.frame_id;
                        end
                    end
                end else if (hit && rx_phase == PH_RECV && pci == PCI_CONSEC
                             && req.frame_id == sender) begin
                    if (b0[3:0] != next_seq) begin
                        drop_transfer();
                        batch.push_back(status_result(ST_ERR, 8'd0, 8'd0));
                    end else begin
                        remain = (msg_total > bytes_done) ? msg_total - bytes_done : 8'd0;
                        take   = (remain < 8'd7) ? remain : 8'd7;
                        batch.push_back(chunk_result(req.frame_bytes, 1, take, bytes_done));
                        bytes_done = bytes_done + take;
                        next_seq   = next_seq + 1'b1;
                        gap_count  = '0;
                        if (bytes_done >= msg_total) begin
                            drop_transfer();
                            batch.push_back(status_result(ST_OK, msg_total, 8'd0));
                        end
                    end
                end
            end
            default: begin
                // unused operation code: no effect
            end
        endcase
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i]) begin
            expected_results.push_back(batch[i]);
        end
    endtask

    // observe both channels at each edge, predict before comparing
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            rx_phase   = PH_IDLE;
            wait_left  = '0;
            gap_count  = '0;
            next_seq   = 4'd1;
            bytes_done = '0;
            msg_total  = '0;
            sender     = '0;
            len_limit  = 8'd255;
            gap_limit  = 8'd50;
            fails      = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MAX_LENGTH) begin
                    len_limit = cfg_wdata;
                end else begin
                    gap_limit = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                req_seen = {s_tuser, s_tdata[15:0], s_tdata[44:16], s_tdata[45], s_tdata[109:46]};
                reassemble(req_seen);
            end
            if (m_tvalid && m_tready) begin
                seen                = '0;
                seen.kind           = m_tuser;
                seen.chunk_bytes    = m_tdata[55:0];
                seen.chunk_count    = m_tdata[58:56];
                seen.byte_offset    = m_tdata[66:59];
                seen.fc_id          = m_tdata[95:67];
                seen.flow_status    = m_tdata[97:96];
                seen.status         = m_tdata[99:98];
                seen.message_length = m_tdata[107:100];
                seen.nrc            = m_tdata[115:108];
                seen.last           = m_tlast;
                if (expected_results.size() == 0) begin
                    note_failure({"unexpected result: ", describe(seen)});
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        note_failure({"result mismatch\n  expected: ", describe(want),
                                      "\n  actual:   ", describe(seen)});
                    end
                end
            end
        end
        mismatches  <= fails;
        outstanding <= expected_results.size();
    end

endmodule

// ===== verif/isotp_response_reassembler_tb.sv =====
// Testbench top for the ISO-TP response reassembler: clock, reset, request and
// configuration stimulus, result back-pressure, watchdog and verdict.
// Depends on isotp_pkg, isotp_response_reassembler and isotp_reassembly_checker.
`timescale 1ns / 1ps

module isotp_response_reassembler_tb;
    import isotp_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_ITEMS   = 1650;
    localparam int          PHASES         = 8;
    localparam int          SETTLE_CYCLES  = 8;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [28:0] STD_RESP       = 29'h7E8;
    localparam logic [28:0] EXT_RESP       = 29'h18DAF100;
    localparam logic [7:0]  NEG_BYTE       = 8'h7F;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [7:0]   cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    int mismatch_count;
    int outstanding;

    int          quiet_cycles = 0;
    int          burst_left   = 0;
    bit          pacing_on    = 1'b1;
    int          sent_items   = 0;
    int          target_items = 0;
    logic [7:0]  cur_max      = 8'd255;
    logic [7:0]  cur_gap      = 8'd50;
    ready_mode_t ready_mode   = READY_ALWAYS;
    int          ready_span   = 0;
    int          ready_count  = 0;

    always #5 aclk = ~aclk;

    isotp_response_reassembler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    isotp_reassembly_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatch_count),
        .outstanding (outstanding)
    );

    // watchdog: ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL isotp_response_reassembler");
            $finish;
        end
    end

    // result back-pressure: switches between stall patterns after spans of random length
    always @(posedge aclk) begin
        ready_count <= ready_count + 1;
        if (ready_span == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_span <= $urandom_range(20, 300);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:      m_tready <= (ready_count % 5 != 0);
        endcase
    end

    function automatic logic [63:0] random_bytes();
        return {$urandom, $urandom};
    endfunction

    // random frame data with a chosen first byte
    function automatic logic [63:0] with_head(input logic [7:0] b0);
        logic [63:0] r;
        r = random_bytes();
        r[63:56] = b0;
        return r;
    endfunction

    // one request; bursts of random length separated by random gaps
    task automatic send_request(input logic [1:0] op, input logic [15:0] wait_v,
                                input logic [28:0] id, input logic ext,
                                input logic [63:0] fb, input bit counted);
        int gap;
        if (burst_left == 0) begin
            gap = (pacing_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, fb, ext, id, wait_v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (counted) begin
            sent_items++;
        end
    endtask

    task automatic send_start(input logic [15:0] wait_v);
        send_request(OP_START, wait_v, 29'($urandom), 1'($urandom), random_bytes(), 1'b1);
    endtask

    task automatic send_tick();
        send_request(OP_TICK, 16'($urandom), 29'($urandom), 1'($urandom), random_bytes(), 1'b1);
    endtask

    task automatic send_frame(input logic [28:0] id, input logic ext, input logic [63:0] fb);
        send_request(OP_FRAME, 16'($urandom), id, ext, fb, 1'b1);
    endtask

    // frames that the response filter rejects, and the unused operation code
    task automatic send_noise();
        logic [28:0] id;
        logic        ext;
        logic [1:0]  op;
        op  = OP_FRAME;
        ext = 1'b1;
        case ($urandom_range(0, 4))
            0: id = 29'($urandom);
            1: begin
                id  = EXT_RESP | 29'($urandom_range(0, 255));
                ext = 1'b0;
            end
            2: id = STD_RESP;
            3: begin
                id  = 29'($urandom_range(0, 2047));
                ext = 1'b0;
            end
            default: begin
                id  = 29'($urandom);
                ext = 1'($urandom);
                op  = OP_UNUSED;
            end
        endcase
        send_request(op, 16'($urandom), id, ext, random_bytes(), 1'b0);
    endtask

    // idle the sender until every predicted result is out, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic program_limits(input logic [7:0] max_len, input logic [7:0] gap_ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_LENGTH;
        cfg_wdata <= max_len;
        @(posedge aclk);
        cfg_index <= CFG_GAP_TIMEOUT;
        cfg_wdata <= gap_ms;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_max = max_len;
        cur_gap = gap_ms;
    endtask

    // consecutive frames of a multi-frame reply, with ticks, strays and faults mixed in
    task automatic stream_consecutive(input logic [28:0] sid, input int unsigned tl);
        int unsigned frames;
        int unsigned roll;
        int unsigned ticks;
        frames = (tl - 6 + 6) / 7;
        for (int i = 1; i <= frames; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                // restart in the middle of a transfer
                send_start(16'($urandom_range(1, 12)));
                return;
            end
            if (roll < 5 && cur_gap <= 20) begin
                repeat (cur_gap + 1) send_tick();
                return;
            end
            if (roll < 8) begin
                send_frame(sid, 1'b1, with_head({PCI_CONSEC, 4'(i + 1 + $urandom_range(0, 14))}));
                return;
            end
            if (roll < 12) begin
                send_noise();
            end else if (roll < 16) begin
                case ($urandom_range(0, 2))
                    0: send_frame(sid ^ 29'h1, 1'b1, with_head({PCI_CONSEC, 4'(i)}));
                    1: send_frame(sid, 1'b1, with_head({4'h3, 4'($urandom)}));
                    default: send_frame(sid, 1'b1, with_head({PCI_SINGLE, 4'($urandom)}));
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                ticks = 0;
            end else if (roll < 95) begin
                ticks = $urandom_range(1, 2);
            end else begin
                ticks = $urandom_range(0, (cur_gap < 20) ? cur_gap : 20);
            end
            repeat (ticks) send_tick();
            send_frame(sid, 1'b1, with_head({PCI_CONSEC, 4'(i)}));
        end
    endtask

    // one armed receive: start, a few ticks or noise, then a response of some shape
    task automatic run_exchange();
        int unsigned roll;
        int unsigned tl;
        int unsigned w;
        logic [28:0] sid;
        logic        sid_ext;
        logic [63:0] fb;
        logic [7:0]  len;

        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            w = 0;
        end else if (roll < 7) begin
            w = $urandom_range(0, 65535);
        end else if (roll < 9) begin
            w = 65535;
        end else begin
            w = $urandom_range(1, 12);
        end
        send_start(16'(w));
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0) begin
                send_noise();
            end else begin
                send_tick();
            end
        end

        sid_ext = ($urandom_range(0, 4) != 0);
        sid     = sid_ext ? (EXT_RESP | 29'($urandom_range(0, 255))) : STD_RESP;
        roll    = $urandom_range(0, 99);
        if (roll < 35) begin
            // single frame, mostly well formed
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(0, 1) ? 8'($urandom_range(8, 15)) : 8'd0;
            end else begin
                len = 8'($urandom_range(1, 7));
            end
            fb = with_head({PCI_SINGLE, len[3:0]});
            if ($urandom_range(0, 3) == 0) begin
                fb[55:48] = NEG_BYTE;
            end
            send_frame(sid, sid_ext, fb);
        end else if (roll < 90) begin
            // first frame, mostly short messages
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                tl = $urandom_range(8, 48);
            end else if (roll == 7) begin
                tl = cur_max;
            end else if (roll == 8) begin
                tl = $urandom_range(0, 4095);
            end else begin
                tl = $urandom_range(0, 7);
            end
            fb = with_head({PCI_FIRST, 4'(tl >> 8)});
            fb[55:48] = 8'(tl);
            send_frame(sid, sid_ext, fb);
            if (sid_ext && tl >= 8 && tl <= cur_max) begin
                stream_consecutive(sid, tl);
            end
        end else begin
            // consecutive, flow-control or reserved frame types while awaiting
            send_frame(sid, sid_ext, with_head({4'($urandom_range(2, 15)), 4'($urandom)}));
        end
    endtask

    initial begin
        logic [63:0] fb;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: idle behavior, each frame type and its error cases
        program_limits(8'd255, 8'd2);
        send_tick();
        send_frame(STD_RESP, 1'b0, with_head({PCI_SINGLE, 4'd3}));
        send_request(OP_UNUSED, 16'hFFFF, 29'h1FFFFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_start(16'd0);
        send_start(16'd2);
        send_tick();
        send_tick();
        send_start(16'hFFFF);
        fb = with_head({PCI_SINGLE, 4'd7});
        fb[55:48] = NEG_BYTE;
        send_frame(STD_RESP, 1'b0, fb);
        send_start(16'd9);
        send_frame(EXT_RESP | 29'hAB, 1'b1, with_head({PCI_SINGLE, 4'd0}));
        send_start(16'd9);
        send_frame(EXT_RESP | 29'hAB, 1'b1, with_head({PCI_SINGLE, 4'd15}));
        send_start(16'd9);
        send_frame(STD_RESP, 1'b0, {PCI_FIRST, 4'd0, 8'd20, 48'h0});
        send_frame(EXT_RESP | 29'hAB, 1'b1, with_head({PCI_CONSEC, 4'd1}));
        send_frame(EXT_RESP | 29'hAB, 1'b1, {PCI_FIRST, 4'hF, 8'hFF, 48'hFFFF_FFFF_FFFF});
        send_start(16'd9);
        send_frame(EXT_RESP | 29'hAB, 1'b1, {PCI_FIRST, 4'd0, 8'd5, 48'h0});
        send_start(16'd9);
        send_frame(EXT_RESP | 29'hAB, 1'b1, {PCI_FIRST, 4'd0, 8'd20, 48'h0102_0304_0506});
        send_frame(EXT_RESP | 29'hAB, 1'b1, with_head({PCI_CONSEC, 4'd1}));
        send_start(16'd3);
        send_frame(EXT_RESP | 29'hFF, 1'b1, {PCI_FIRST, 4'd0, 8'd8, 48'hA1A2_A3A4_A5A6});
        send_tick();
        send_tick();
        send_tick();
        send_start(16'd9);
        send_frame(EXT_RESP, 1'b1, {PCI_FIRST, 4'd0, 8'd13, 48'h0});
        send_frame(EXT_RESP, 1'b1, with_head({PCI_CONSEC, 4'd2}));
        settle();

        // random part over several register settings, extremes first
        target_items = sent_items;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_limits(8'd255, 8'd255);
                1: program_limits(8'd0, 8'd1);
                2: program_limits(8'd7, 8'd1);
                3: program_limits(8'd8, 8'd3);
                4: program_limits(8'd255, 8'd50);
                default: program_limits(8'($urandom_range(8, 255)), 8'($urandom_range(1, 12)));
            endcase
            pacing_on    = (p % 3 != 1);
            target_items = target_items + RANDOM_ITEMS / PHASES;
            while (sent_items < target_items) run_exchange();
            settle();
        end

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASS isotp_response_reassembler");
        end else begin
            $display("FAIL isotp_response_reassembler");
        end
        $finish;
    end

endmodule
